FILE: sv/bsfe_pkg.sv
// Shared types, constants and the FCS-16 byte update for the byte-stuffing encoder.
// No dependencies; the front end, queue, back end and top module import this package.
package bsfe_pkg;

    localparam logic [15:0] CRC_POLY      = 16'h8408;
    localparam logic [7:0]  STUFF_XOR     = 8'h20;
    localparam logic [15:0] CRC_START_RST = 16'hFFFF;
    localparam logic [7:0]  FLAG_RST      = 8'h7E;
    localparam logic [7:0]  ESCAPE_RST    = 8'h7D;

    localparam int          CFG_IDX_W     = 2;
    localparam int          CFG_DATA_W    = 16;

    localparam logic [CFG_IDX_W-1:0] REG_CRC_START = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FLAG      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ESCAPE    = 2'd2;

    typedef struct packed {
        logic [15:0] crc_start;
        logic [7:0]  flag_value;
        logic [7:0]  escape_value;
    } t_cfg;

    typedef struct packed {
        logic [7:0]  data_byte;
        logic        first_byte;
        logic        last_byte;
        logic [15:0] crc;
    } t_cmd;

    function automatic logic [15:0] fcs_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

FILE: sv/bsfe_in_if.sv
// Input channel of the encoder: one frame content byte with first and last marks.
// No dependencies.
interface bsfe_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       first_byte;
    logic       last_byte;

    modport source (output valid, data_byte, first_byte, last_byte, input ready);
    modport sink   (input valid, data_byte, first_byte, last_byte, output ready);
endinterface

FILE: sv/bsfe_out_if.sv
// Output channel of the encoder: one line byte with the end-of-run mark.
// No dependencies.
interface bsfe_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] line_byte;
    logic       run_end;

    modport source (output valid, line_byte, run_end, input ready);
    modport sink   (input valid, line_byte, run_end, output ready);
endinterface

FILE: sv/bsfe_front.sv
// Front end: accepts content bytes, keeps the running FCS-16 and queues one command per item.
// Depends on bsfe_pkg and bsfe_in_if.
module bsfe_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  bsfe_pkg::t_cfg    i_cfg,
    bsfe_in_if.sink           i_in,
    output logic              o_wr_valid,
    input  logic              i_wr_ready,
    output bsfe_pkg::t_cmd    o_wr_cmd
);
    import bsfe_pkg::*;

    logic [15:0] r_crc;
    logic [15:0] n_crc;
    logic [15:0] crc_base;
    logic        accept;

    assign i_in.ready = i_wr_ready;
    assign accept     = i_in.valid && i_wr_ready;
    assign crc_base   = i_in.first_byte ? i_cfg.crc_start : r_crc;
    assign n_crc      = fcs_byte(crc_base, i_in.data_byte);

    assign o_wr_valid          = i_in.valid;
    assign o_wr_cmd.data_byte  = i_in.data_byte;
    assign o_wr_cmd.first_byte = i_in.first_byte;
    assign o_wr_cmd.last_byte  = i_in.last_byte;
    assign o_wr_cmd.crc        = n_crc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc <= CRC_START_RST;
        end else if (accept) begin
            r_crc <= n_crc;
        end
    end

endmodule

FILE: sv/bsfe_queue.sv
// Command queue between front and back end, built from flip-flops.
// Depends on bsfe_pkg.
module bsfe_queue #(
    parameter int DEPTH = 4
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_wr_valid,
    output logic           o_wr_ready,
    input  bsfe_pkg::t_cmd i_wr_cmd,
    output logic           o_rd_valid,
    input  logic           i_rd_pop,
    output bsfe_pkg::t_cmd o_rd_cmd
);
    import bsfe_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_cmd          r_mem [DEPTH];
    logic [PW-1:0] r_wr_ptr;
    logic [PW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;
    logic          push;
    logic          pop;

    assign o_wr_ready = (r_count < CW'(DEPTH));
    assign o_rd_valid = (r_count != '0);
    assign o_rd_cmd   = r_mem[r_rd_ptr];
    assign push       = i_wr_valid && o_wr_ready;
    assign pop        = i_rd_pop && o_rd_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_wr_cmd;
        end
    end

endmodule

FILE: sv/bsfe_back.sv
// Back end: per command, flag if first, escaped data, escaped CRC and end flag if last.
// Depends on bsfe_pkg and bsfe_out_if.
module bsfe_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  bsfe_pkg::t_cfg i_cfg,
    input  logic           i_rd_valid,
    input  bsfe_pkg::t_cmd i_rd_cmd,
    output logic           o_rd_pop,
    bsfe_out_if.source     o_out
);
    import bsfe_pkg::*;

    localparam logic [2:0] ST_FLAG_OPEN  = 3'd0;
    localparam logic [2:0] ST_DATA       = 3'd1;
    localparam logic [2:0] ST_CRC_LO     = 3'd2;
    localparam logic [2:0] ST_CRC_HI     = 3'd3;
    localparam logic [2:0] ST_FLAG_CLOSE = 3'd4;

    logic [2:0] r_step;
    logic       r_half;
    logic       r_valid;
    logic [7:0] r_byte;
    logic       r_end;

    logic [2:0] step;
    logic [2:0] next_step;
    logic [2:0] n_step;
    logic       n_half;
    logic [7:0] raw;
    logic [7:0] n_byte;
    logic       stuffable;
    logic       hit;
    logic       step_done;
    logic       end_step;
    logic       item_done;
    logic       emit;

    always_comb begin
        step = (r_step == ST_FLAG_OPEN && !i_rd_cmd.first_byte) ? ST_DATA : r_step;

        case (step)
            ST_FLAG_OPEN: begin
                raw = i_cfg.flag_value; stuffable = 1'b0;
                next_step = ST_DATA; end_step = 1'b0;
            end
            ST_DATA: begin
                raw = i_rd_cmd.data_byte; stuffable = 1'b1;
                next_step = i_rd_cmd.last_byte ? ST_CRC_LO : ST_FLAG_OPEN;
                end_step  = !i_rd_cmd.last_byte;
            end
            ST_CRC_LO: begin
                raw = i_rd_cmd.crc[7:0]; stuffable = 1'b1;
                next_step = ST_CRC_HI; end_step = 1'b0;
            end
            ST_CRC_HI: begin
                raw = i_rd_cmd.crc[15:8]; stuffable = 1'b1;
                next_step = ST_FLAG_CLOSE; end_step = 1'b0;
            end
            ST_FLAG_CLOSE: begin
                raw = i_cfg.flag_value; stuffable = 1'b0;
                next_step = ST_FLAG_OPEN; end_step = 1'b1;
            end
            default: begin
                raw = i_cfg.flag_value; stuffable = 1'b0;
                next_step = ST_FLAG_OPEN; end_step = 1'b1;
            end
        endcase

        hit = stuffable && (raw == i_cfg.flag_value || raw == i_cfg.escape_value);

        if (hit && !r_half) begin
            n_byte    = i_cfg.escape_value;
            step_done = 1'b0;
        end else if (hit) begin
            n_byte    = raw ^ STUFF_XOR;
            step_done = 1'b1;
        end else begin
            n_byte    = raw;
            step_done = 1'b1;
        end

        item_done = step_done && end_step;
        n_step    = step_done ? next_step : r_step;
        n_half    = !step_done;
        emit      = i_rd_valid && (!r_valid || o_out.ready);
    end

    assign o_rd_pop        = emit && item_done;
    assign o_out.valid     = r_valid;
    assign o_out.line_byte = r_byte;
    assign o_out.run_end   = r_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step  <= ST_FLAG_OPEN;
            r_half  <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            if (emit) begin
                r_step  <= n_step;
                r_half  <= n_half;
                r_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_byte <= n_byte;
            r_end  <= item_done;
        end
    end

endmodule

FILE: sv/byte_stuffing_frame_encoder.sv
// Byte-stuffing frame encoder with FCS-16: config registers, front end, queue, back end.
// Depends on bsfe_pkg, bsfe_in_if, bsfe_out_if, bsfe_front, bsfe_queue and bsfe_back.
// An accepted item is stored in the queue, then its first line byte in r_byte.
// Throughput: one line byte per cycle unless stalled; an item yields 1 to 8 line bytes.
// Input is taken every cycle while the QUEUE_DEPTH-entry command queue has room.
// Reset: registers to 0xFFFF/0x7E/0x7D, running CRC to 0xFFFF, queue and output emptied.
module byte_stuffing_frame_encoder #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    bsfe_in_if.sink                             i_in,
    bsfe_out_if.source                          o_out,
    input  logic                                i_cfg_we,
    input  logic [bsfe_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [bsfe_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import bsfe_pkg::*;

    t_cfg r_cfg;
    t_cmd wr_cmd;
    t_cmd rd_cmd;
    logic wr_valid;
    logic wr_ready;
    logic rd_valid;
    logic rd_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.crc_start    <= CRC_START_RST;
            r_cfg.flag_value   <= FLAG_RST;
            r_cfg.escape_value <= ESCAPE_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_CRC_START: r_cfg.crc_start    <= i_cfg_data;
                REG_FLAG:      r_cfg.flag_value   <= i_cfg_data[7:0];
                REG_ESCAPE:    r_cfg.escape_value <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    bsfe_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_in       (i_in),
        .o_wr_valid (wr_valid),
        .i_wr_ready (wr_ready),
        .o_wr_cmd   (wr_cmd)
    );

    bsfe_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_valid (wr_valid),
        .o_wr_ready (wr_ready),
        .i_wr_cmd   (wr_cmd),
        .o_rd_valid (rd_valid),
        .i_rd_pop   (rd_pop),
        .o_rd_cmd   (rd_cmd)
    );

    bsfe_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_rd_valid (rd_valid),
        .i_rd_cmd   (rd_cmd),
        .o_rd_pop   (rd_pop),
        .o_out      (o_out)
    );

endmodule
